// ===== rtl/core/mqc_pkg.sv =====
package mqc_pkg;

  // Default build: eight channels of 32-bit counters.
  localparam int CHANNELS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 32;

  // Opcodes carried in the low bits of s_tuser.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register offsets in the 16-bit window.
  localparam logic [1:0] REG_INDEX = 2'd0;
  localparam logic [1:0] REG_CNT_LO = 2'd1;
  localparam logic [1:0] REG_CNT_HI = 2'd2;
  localparam logic [1:0] REG_CTRL  = 2'd3;

  // Index register bits.
  localparam int IX_AUTOINC_BIT = 14;
  localparam int IX_GCLEAR_BIT  = 13;
  localparam int IX_GHOLD_BIT   = 12;
  localparam logic [15:0] IX_GLOBAL_MASK = 16'h3000;

  // Counter control bits.
  localparam int CC_AUTO_BIT   = 11;
  localparam int CC_UPDOWN_BIT = 10;
  localparam int CC_LHOLD_BIT  = 8;
  localparam int CC_GATE_BIT   = 7;
  localparam int CC_ONCE_BIT   = 6;
  localparam int CC_CLRIDX_BIT = 5;
  localparam int CC_POL_BIT    = 4;
  localparam int CC_LATCH_BIT  = 3;
  localparam int CC_IDXCLR_BIT = 2;
  localparam logic [15:0] CC_WRITABLE = 16'h0FF8;

  // What one channel sees in the cycle an item is processed.
  typedef struct packed {
    logic        tick;
    logic        gclear;
    logic        ghold;
    logic        pin_a;
    logic        pin_b;
    logic        pin_ix;
    logic        old_a;
    logic        old_b;
    logic        old_ix;
    logic        latch;
    logic        ctrl_wr;
    logic [15:0] ctrl_data;
  } chan_cmd_t;

  // 4X Gray decode: returns {up, down} for an old and a new {A, B} state.
  function automatic logic [1:0] quad_dir(input logic [1:0] old_ab,
                                          input logic [1:0] new_ab);
    logic [1:0] dir;
    dir = 2'b00;
    case ({old_ab, new_ab}) inside
      4'b0010, 4'b0100, 4'b1011, 4'b1101: dir = 2'b10;
      4'b0001, 4'b0111, 4'b1000, 4'b1110: dir = 2'b01;
      default: dir = 2'b00;
    endcase
    return dir;
  endfunction

endpackage

// ===== rtl/core/multichannel_quadrature_counter.sv =====
// Multichannel quadrature counter: up to eight encoder counters (CHANNELS) of
// COUNT_BITS bits each, reached through a 16-bit register window. Each input
// beat's opcode makes it a tick that samples the A, B and index pins of all
// channels, a register read or a register write; opcode 3 does nothing.
// Every input beat, whatever its kind, produces exactly one output beat; it
// carries the register word for a read and zero for everything else. The
// block takes one beat per clock and keeps that rate indefinitely as long as
// the output side takes its beats. A beat passes an input register, is decoded
// against the counter state as it leaves that register, and then lands in the
// output register, which holds its result until the
// output side takes it. The input register drains into the output
// register whenever that one is empty or being emptied, so a single waiting
// result does not stop a new beat from being taken; only when both registers
// hold beats and the output side stalls does s_tready drop.
// Drive a tick on every clock on which the encoder pins may change, or
// transitions will be missed.
module multichannel_quadrature_counter
  import mqc_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: write_data[15:0], pins_a[7:0], pins_b[7:0], pins_index[7:0].
  input  logic [39:0] s_tdata,
  // Fields from bit 0: opcode[1:0], reg_offset[1:0].
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: read_data[15:0].
  output logic [15:0] m_tdata
);

  localparam int SEL_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Input register.
  logic        st_valid;
  logic [1:0]  st_op;
  logic [1:0]  st_reg;
  logic [15:0] st_data;
  logic [7:0]  st_a;
  logic [7:0]  st_b;
  logic [7:0]  st_ix;

  // Shared state kept at the top level.
  logic [15:0] index_word;
  logic [15:0] index_word_next;
  logic [7:0]  prev_a;
  logic [7:0]  prev_b;
  logic [7:0]  prev_index;

  // Per-channel state, held inside the channel instances.
  logic [COUNT_BITS-1:0] ch_count   [CHANNELS];
  logic [COUNT_BITS-1:0] ch_latched [CHANNELS];
  logic [15:0]           ch_ctrl    [CHANNELS];
  chan_cmd_t             ch_cmd     [CHANNELS];

  logic             advance;
  logic [2:0]       sel;
  logic [SEL_W-1:0] sel_idx;
  logic             present;
  logic             is_tick;
  logic             is_read;
  logic             is_write;
  logic             sel_latch;
  logic [31:0]      sel_value;
  logic [15:0]      read_word;

  // The processing step moves when the output register is free or draining.
  assign advance  = st_valid && (!m_tvalid || m_tready);
  assign s_tready = !st_valid || advance;

  assign is_tick  = advance && (st_op == OP_TICK);
  assign is_read  = advance && (st_op == OP_READ);
  assign is_write = advance && (st_op == OP_WRITE);

  assign sel       = index_word[2:0];
  assign sel_idx   = sel[SEL_W-1:0];
  assign present   = {1'b0, sel} < 4'(CHANNELS);
  assign sel_latch = ch_ctrl[sel_idx][CC_LATCH_BIT];

  // With latch-on-read set, a counter-low read refreshes the latch first, so
  // it returns the live count; counter-high then returns the latch.
  assign sel_value = (sel_latch && (st_reg == REG_CNT_HI)) ?
                     32'(ch_latched[sel_idx]) : 32'(ch_count[sel_idx]);

  always_comb begin
    read_word = '0;
    unique case (st_reg)
      REG_INDEX: begin
        read_word = index_word;
      end
      REG_CNT_LO: begin
        if (present) begin
          read_word = sel_value[15:0];
        end
      end
      REG_CNT_HI: begin
        if (present) begin
          read_word = sel_value[31:16];
        end
      end
      REG_CTRL: begin
        if (present) begin
          read_word = ch_ctrl[sel_idx] | (index_word & IX_GLOBAL_MASK) |
                      {13'd0, prev_index[sel], prev_b[sel], prev_a[sel]};
        end
      end
      default: read_word = '0;
    endcase
  end

  // Index register: written directly, or stepped by a counter-high read with
  // auto-increment set (the select wraps within three bits).
  always_comb begin
    index_word_next = index_word;
    if (is_write && (st_reg == REG_INDEX)) begin
      index_word_next = st_data;
    end else if (is_read && (st_reg == REG_CNT_HI) && index_word[IX_AUTOINC_BIT]) begin
      index_word_next[2:0] = sel + 3'd1;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic hit;
    assign hit = present && (sel_idx == SEL_W'(c));

    always_comb begin
      ch_cmd[c].tick      = is_tick;
      ch_cmd[c].gclear    = index_word[IX_GCLEAR_BIT];
      ch_cmd[c].ghold     = index_word[IX_GHOLD_BIT];
      ch_cmd[c].pin_a     = st_a[c];
      ch_cmd[c].pin_b     = st_b[c];
      ch_cmd[c].pin_ix    = st_ix[c];
      ch_cmd[c].old_a     = prev_a[c];
      ch_cmd[c].old_b     = prev_b[c];
      ch_cmd[c].old_ix    = prev_index[c];
      // A counter-high write latches every channel; a counter-low read with
      // latch-on-read set latches only the selected one.
      ch_cmd[c].latch     = (is_write && (st_reg == REG_CNT_HI)) ||
                            (is_read && (st_reg == REG_CNT_LO) && hit &&
                             ch_ctrl[c][CC_LATCH_BIT]);
      ch_cmd[c].ctrl_wr   = is_write && (st_reg == REG_CTRL) && hit;
      ch_cmd[c].ctrl_data = st_data;
    end

    mqc_channel #(
      .COUNT_BITS(COUNT_BITS)
    ) u_channel (
      .clk    (clk),
      .rst    (rst),
      .cmd    (ch_cmd[c]),
      .count  (ch_count[c]),
      .latched(ch_latched[c]),
      .ctrl   (ch_ctrl[c])
    );
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      st_valid <= 1'b1;
    end else if (advance) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      st_op   <= s_tuser[1:0];
      st_reg  <= s_tuser[3:2];
      st_data <= s_tdata[15:0];
      st_a    <= s_tdata[23:16];
      st_b    <= s_tdata[31:24];
      st_ix   <= s_tdata[39:32];
    end
  end

  // Shared state.
  always_ff @(posedge clk) begin
    if (rst) begin
      index_word <= '0;
      prev_a     <= '0;
      prev_b     <= '0;
      prev_index <= '0;
    end else begin
      index_word <= index_word_next;
      if (is_tick) begin
        prev_a     <= st_a;
        prev_b     <= st_b;
        prev_index <= st_ix;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= is_read ? read_word : 16'd0;
    end
  end

endmodule

// ===== rtl/core/mqc_channel.sv =====
module mqc_channel
  import mqc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  chan_cmd_t             cmd,
  output logic [COUNT_BITS-1:0] count,
  output logic [COUNT_BITS-1:0] latched,
  output logic [15:0]           ctrl
);

  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] latched_next;
  logic [15:0]           ctrl_next;
  logic                  ix_event;
  logic                  hold;
  logic [1:0]            dir;

  always_comb begin
    count_next   = count;
    latched_next = latched;
    ctrl_next    = ctrl;
    ix_event = ctrl[CC_POL_BIT] ? (!cmd.old_ix && cmd.pin_ix) : (cmd.old_ix && !cmd.pin_ix);
    if (ctrl[CC_GATE_BIT] && (cmd.pin_a || cmd.pin_b)) begin
      ix_event = 1'b0;
    end
    hold = cmd.ghold || ctrl[CC_LHOLD_BIT];
    dir  = quad_dir({cmd.old_a, cmd.old_b}, {cmd.pin_a, cmd.pin_b});

    if (cmd.tick) begin
      if (cmd.gclear) begin
        count_next = '0;
      end else if (ix_event && ctrl[CC_CLRIDX_BIT]) begin
        // An index clear wins over both holds.
        count_next = '0;
        if (ctrl[CC_ONCE_BIT]) begin
          ctrl_next[CC_CLRIDX_BIT] = 1'b0;
        end
      end else if (!hold) begin
        if (ctrl[CC_AUTO_BIT]) begin
          count_next = count + 1'b1;
        end else if (ctrl[CC_UPDOWN_BIT]) begin
          if (!cmd.old_a && cmd.pin_a) begin
            count_next = cmd.pin_b ? count + 1'b1 : count - 1'b1;
          end
        end else if (dir[1]) begin
          count_next = count + 1'b1;
        end else if (dir[0]) begin
          count_next = count - 1'b1;
        end
      end
    end else if (cmd.ctrl_wr) begin
      ctrl_next = cmd.ctrl_data & CC_WRITABLE;
      if (cmd.ctrl_data[CC_IDXCLR_BIT]) begin
        count_next = '0;
      end
    end

    if (cmd.latch) begin
      latched_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      latched <= '0;
      ctrl    <= '0;
    end else begin
      count   <= count_next;
      latched <= latched_next;
      ctrl    <= ctrl_next;
    end
  end

endmodule
